@@ rtl/core/fdc_pkg.sv @@
// Package with shared types and constants of the floppy disk controller.
`timescale 1ns / 1ps
package fdc_pkg;

    localparam int SECTOR_BYTES   = 512;
    localparam int IMAGE_SECTORS  = 80 * 2 * 9;
    localparam int IMAGE_BYTES    = IMAGE_SECTORS * SECTOR_BYTES;
    localparam int ACT_W          = $clog2(IMAGE_SECTORS + 1);
    localparam int BUF_AW         = $clog2(SECTOR_BYTES);
    localparam int POS_W          = BUF_AW + 1;
    localparam int IMG_AW         = ACT_W + BUF_AW;

    // Status register bits.
    localparam logic [7:0] ST_BUSY = 8'h01;
    localparam logic [7:0] ST_DRQ  = 8'h02;
    localparam logic [7:0] ST_TRK0 = 8'h04;
    localparam logic [7:0] ST_CRC  = 8'h08;
    localparam logic [7:0] ST_RNF  = 8'h10;
    localparam logic [7:0] ST_SPIN = 8'h20;
    localparam logic [7:0] ST_WP   = 8'h40;
    localparam logic [7:0] ST_NRDY = 8'h80;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_SIDE   = 3'd2;
    localparam logic [2:0] OP_CLRCHG = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    localparam logic [1:0] REG_STATUS = 2'd0;
    localparam logic [1:0] REG_TRACK  = 2'd1;
    localparam logic [1:0] REG_SECTOR = 2'd2;
    localparam logic [1:0] REG_DATA   = 2'd3;

    localparam logic [2:0] CFG_IMAGE   = 3'd0;
    localparam logic [2:0] CFG_WPROT   = 3'd1;
    localparam logic [2:0] CFG_TRACKS  = 3'd2;
    localparam logic [2:0] CFG_SIDES   = 3'd3;
    localparam logic [2:0] CFG_SPT     = 3'd4;
    localparam logic [2:0] CFG_VARIANT = 3'd5;

    // Command codes, matched against the high bits of the command byte.
    localparam logic [3:0] CMD_RESTORE = 4'h0;
    localparam logic [3:0] CMD_SEEK    = 4'h1;
    localparam logic [3:0] CMD_FORCE   = 4'hD;
    localparam logic [3:0] CMD_RDMULTI = 4'h9;
    localparam logic [2:0] CMD_WRSECT  = 3'b101;
    localparam logic [2:0] CMD_STEPIN  = 3'b010;
    localparam logic [2:0] CMD_STEPOUT = 3'b011;
    localparam logic [4:0] CMD_FORCE_IRQ = 5'b11011;

    localparam logic [POS_W-1:0] ID_POS = POS_W'(SECTOR_BYTES - 6);
    localparam logic [10:0] STEP_LIMIT = 11'd1024;

    typedef enum logic [3:0] {
        S_IDLE, S_RDBUF, S_CMD, S_SEEK, S_T1FIN, S_LOC1, S_LOC2, S_LOC3,
        S_RDSEC, S_WRSEC, S_FILL, S_IDBYTES, S_T4FIN, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        LK_RDSEC, LK_WRCMD, LK_WRDONE
    } loc_kind_t;

    typedef struct packed {
        logic [7:0] track;
        logic [1:0] sides;
        logic       side;
        logic [3:0] spt;
        logic [7:0] sector;
    } loc_req_t;

endpackage

@@ rtl/core/fdc_locate.sv @@
// Two-stage multiply-add unit that turns a head position into a sector index.
`timescale 1ns / 1ps
module fdc_locate (
    input  logic                      clk,
    input  fdc_pkg::loc_req_t         req,
    output logic [fdc_pkg::ACT_W-1:0] act
);
    import fdc_pkg::*;

    logic [9:0]       p_reg;
    logic [13:0]      idx;
    logic [ACT_W-1:0] act_reg;

    // Stage two uses the track/side product from the cycle before.
    assign idx = 14'(p_reg) * 14'(req.spt) + 14'(req.sector) - 14'd1;

    always_ff @(posedge clk)
    begin
        p_reg   <= 10'(req.track) * 10'(req.sides) + 10'(req.side);
        act_reg <= (idx < 14'(IMAGE_SECTORS)) ? ACT_W'(idx) : ACT_W'(IMAGE_SECTORS);
    end

    assign act = act_reg;

endmodule

@@ rtl/core/floppy_disk_controller_top.sv @@
// Top level of the floppy disk controller: register file, command sequencer and stores.
`timescale 1ns / 1ps
//
//  Channel   Direction  Carries
//  s_*       in         one bus operation (read, write, side, clear change, image load)
//  m_*       out        one result per operation: read data and the three line levels
//  cfg_*     in         configuration register writes, no handshake
//
// The result of a register access, side select, change clear or image load is registered
// in the S_DONE state that follows its transfer and then offered; data reads and commands
// add sequencer steps on top. A seek steps the head one track per S_SEEK step, sector
// reads and writes add a copy of the whole sector between image and sector buffer, plus
// the S_LOC1, S_LOC2 and S_LOC3 states for the multiply-add position unit. One item is
// handled at a time; ready stays low while a result waits to be taken. Reset clears all
// control state; the sector buffer and the disk image keep their contents and need no
// clearing pass.
module floppy_disk_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], register_select[4:3], write_value[12:5],
    // image_address[32:13], image_byte[40:33], zero fill [47:41]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], interrupt_request[8], data_request[9], disk_changed[10],
    // zero fill [15:11]
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [6:0]  cfg_data
);
    import fdc_pkg::*;

    // Configuration registers.
    logic       img_reg, wp_reg, ssv_reg;
    logic [6:0] tc_reg;
    logic [1:0] sc_reg;
    logic [3:0] spt_reg;

    state_t state_reg, state_next;
    loc_kind_t lk_reg, lk_next;
    logic [7:0] status_reg, status_next, last_reg, last_next, trk_reg, trk_next;
    logic [7:0] sec_reg, sec_next, dat_reg, dat_next, ht_reg, ht_next, cmd_reg, cmd_next;
    logic [7:0] rd_reg, rd_next;
    logic hs_reg, hs_next, irq_reg, irq_next, drq_reg, drq_next, chg_reg, chg_next;
    logic stin_reg, stin_next, flush_reg, flush_next, ovalid_reg, ovalid_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [ACT_W-1:0] act_reg, act_next, loc_act;
    logic [10:0] cnt_reg, cnt_next;
    logic [2:0] op_reg, op_next;
    logic [1:0] sel_reg, sel_next;

    logic [2:0]  in_op;
    logic [1:0]  in_sel;
    logic [7:0]  in_val, in_byte;
    logic [19:0] in_addr;
    assign in_op   = s_tdata[2:0];
    assign in_sel  = s_tdata[4:3];
    assign in_val  = s_tdata[12:5];
    assign in_addr = s_tdata[32:13];
    assign in_byte = s_tdata[40:33];

    // Sector buffer and disk image, each one write and one registered read port.
    logic [7:0] sbuf [SECTOR_BYTES];
    logic [7:0] img_mem [IMAGE_BYTES];
    logic              sb_we, im_we;
    logic [BUF_AW-1:0] sb_waddr, sb_raddr;
    logic [7:0]        sb_wdata, sb_q, im_wdata, im_q;
    logic [IMG_AW-1:0] im_waddr, im_raddr;

    always_ff @(posedge clk)
    begin
        if (sb_we)
        begin
            sbuf[sb_waddr] <= sb_wdata;
        end
        sb_q <= sbuf[sb_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (im_we)
        begin
            img_mem[im_waddr] <= im_wdata;
        end
        im_q <= img_mem[im_raddr];
    end

    assign im_raddr = {act_reg, cnt_reg[BUF_AW-1:0]};

    // Position check and sector index.
    loc_req_t loc_req;
    logic     loc_ok, loc_in_store;
    assign loc_req = '{track: ht_reg, sides: sc_reg, side: hs_reg, spt: spt_reg,
                       sector: sec_reg};

    fdc_locate u_locate (
        .clk (clk),
        .req (loc_req),
        .act (loc_act)
    );

    assign loc_ok = img_reg && (ht_reg < {1'b0, tc_reg}) && (ht_reg == trk_reg) &&
                    ({1'b0, hs_reg} < sc_reg) && (sec_reg != 8'd0) &&
                    (sec_reg <= {4'd0, spt_reg});
    assign loc_in_store = loc_act < ACT_W'(IMAGE_SECTORS);

    logic accept;
    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, chg_reg, drq_reg, irq_reg, rd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_reg <= 1'b0;
            wp_reg  <= 1'b0;
            tc_reg  <= 7'd80;
            sc_reg  <= 2'd2;
            spt_reg <= 4'd9;
            ssv_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IMAGE:   img_reg <= cfg_data[0];
                CFG_WPROT:   wp_reg  <= cfg_data[0];
                CFG_TRACKS:  tc_reg  <= cfg_data;
                CFG_SIDES:   sc_reg  <= cfg_data[1:0];
                CFG_SPT:     spt_reg <= cfg_data[3:0];
                CFG_VARIANT: ssv_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lk_reg     <= LK_RDSEC;
            status_reg <= ST_SPIN;
            last_reg   <= 8'd0;
            trk_reg    <= 8'd0;
            sec_reg    <= 8'd0;
            dat_reg    <= 8'd0;
            ht_reg     <= 8'd0;
            cmd_reg    <= 8'd0;
            rd_reg     <= 8'd0;
            hs_reg     <= 1'b0;
            irq_reg    <= 1'b0;
            drq_reg    <= 1'b0;
            chg_reg    <= 1'b1;
            stin_reg   <= 1'b0;
            flush_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            pos_reg    <= POS_W'(SECTOR_BYTES);
            act_reg    <= '0;
            cnt_reg    <= '0;
            op_reg     <= OP_READ;
            sel_reg    <= REG_STATUS;
        end
        else
        begin
            state_reg  <= state_next;
            lk_reg     <= lk_next;
            status_reg <= status_next;
            last_reg   <= last_next;
            trk_reg    <= trk_next;
            sec_reg    <= sec_next;
            dat_reg    <= dat_next;
            ht_reg     <= ht_next;
            cmd_reg    <= cmd_next;
            rd_reg     <= rd_next;
            hs_reg     <= hs_next;
            irq_reg    <= irq_next;
            drq_reg    <= drq_next;
            chg_reg    <= chg_next;
            stin_reg   <= stin_next;
            flush_reg  <= flush_next;
            ovalid_reg <= ovalid_next;
            pos_reg    <= pos_next;
            act_reg    <= act_next;
            cnt_reg    <= cnt_next;
            op_reg     <= op_next;
            sel_reg    <= sel_next;
        end
    end

    // Sequencer: one state per step of a command.
    always_comb
    begin
        logic       dir;
        logic [7:0] st;
        logic [7:0] ht_dec;
        state_next  = state_reg;
        lk_next     = lk_reg;
        status_next = status_reg;
        last_next   = last_reg;
        trk_next    = trk_reg;
        sec_next    = sec_reg;
        dat_next    = dat_reg;
        ht_next     = ht_reg;
        cmd_next    = cmd_reg;
        rd_next     = rd_reg;
        hs_next     = hs_reg;
        irq_next    = irq_reg;
        drq_next    = drq_reg;
        chg_next    = chg_reg;
        stin_next   = stin_reg;
        flush_next  = flush_reg;
        ovalid_next = ovalid_reg;
        pos_next    = pos_reg;
        act_next    = act_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        sel_next    = sel_reg;
        sb_we       = 1'b0;
        sb_waddr    = pos_reg[BUF_AW-1:0];
        sb_wdata    = 8'd0;
        sb_raddr    = pos_reg[BUF_AW-1:0];
        im_we       = 1'b0;
        im_waddr    = {act_reg, BUF_AW'(cnt_reg - 11'd1)};
        im_wdata    = sb_q;
        dir         = stin_reg;
        st          = 8'd0;
        ht_dec      = ht_reg - 8'd1;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_op;
                    sel_next   = in_sel;
                    state_next = S_DONE;
                    case (in_op)
                        OP_READ:
                        begin
                            if (in_sel == REG_STATUS)
                            begin
                                if (irq_reg && last_reg[7:3] != CMD_FORCE_IRQ)
                                begin
                                    irq_next = 1'b0;
                                end
                            end
                            else if (in_sel == REG_DATA && drq_reg &&
                                     pos_reg < POS_W'(SECTOR_BYTES))
                            begin
                                state_next = S_RDBUF;
                            end
                        end
                        OP_WRITE:
                        begin
                            case (in_sel)
                                REG_STATUS:
                                begin
                                    cmd_next   = in_val;
                                    state_next = S_CMD;
                                end
                                REG_TRACK:
                                begin
                                    if (!status_reg[0])
                                    begin
                                        trk_next = in_val;
                                    end
                                end
                                REG_SECTOR:
                                begin
                                    if (!status_reg[0])
                                    begin
                                        sec_next = in_val;
                                    end
                                end
                                default:
                                begin
                                    dat_next = in_val;
                                    if (drq_reg && last_reg[7:5] == CMD_WRSECT &&
                                        pos_reg < POS_W'(SECTOR_BYTES))
                                    begin
                                        sb_we    = 1'b1;
                                        sb_wdata = in_val;
                                        pos_next = pos_reg + POS_W'(1);
                                        if (pos_reg == POS_W'(SECTOR_BYTES - 1))
                                        begin
                                            pos_next    = '0;
                                            drq_next    = 1'b0;
                                            status_next = status_reg & ~(ST_BUSY | ST_DRQ);
                                            lk_next     = LK_WRDONE;
                                            state_next  = S_LOC1;
                                        end
                                    end
                                end
                            endcase
                        end
                        OP_SIDE:   hs_next  = in_val[0];
                        OP_CLRCHG: chg_next = 1'b0;
                        OP_LOAD:
                        begin
                            if (in_addr < 20'(IMAGE_BYTES))
                            begin
                                im_we    = 1'b1;
                                im_waddr = IMG_AW'(in_addr);
                                im_wdata = in_byte;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RDBUF:
            begin
                dat_next   = sb_q;
                pos_next   = pos_reg + POS_W'(1);
                state_next = S_DONE;
                if (pos_reg == POS_W'(SECTOR_BYTES - 1))
                begin
                    pos_next    = '0;
                    drq_next    = 1'b0;
                    status_next = status_reg & ~(ST_BUSY | ST_DRQ);
                    if (last_reg[7:4] == CMD_RDMULTI)
                    begin
                        sec_next   = sec_reg + 8'd1;
                        cmd_next   = last_reg;
                        state_next = S_CMD;
                    end
                    else
                    begin
                        last_next = 8'd0;
                        irq_next  = 1'b1;
                    end
                end
            end

            S_CMD:
            begin
                state_next = S_DONE;
                if (!status_reg[0] || cmd_reg[7:4] == CMD_FORCE)
                begin
                    if (!status_reg[0])
                    begin
                        last_next = cmd_reg;
                    end
                    if (!cmd_reg[7])
                    begin
                        // Type I: head positioning.
                        drq_next    = 1'b0;
                        irq_next    = 1'b0;
                        status_next = ST_SPIN | ST_BUSY;
                        state_next  = S_T1FIN;
                        if (cmd_reg[7:4] == CMD_RESTORE)
                        begin
                            if (ht_reg != 8'd0)
                            begin
                                stin_next = 1'b0;
                            end
                            ht_next  = 8'd0;
                            trk_next = 8'd0;
                            dat_next = 8'd0;
                        end
                        else if (cmd_reg[7:4] == CMD_SEEK)
                        begin
                            if (dat_reg != trk_reg)
                            begin
                                stin_next  = dat_reg > trk_reg;
                                cnt_next   = '0;
                                state_next = S_SEEK;
                            end
                        end
                        else
                        begin
                            if (cmd_reg[7:5] == CMD_STEPIN)
                            begin
                                dir = 1'b1;
                            end
                            else if (cmd_reg[7:5] == CMD_STEPOUT)
                            begin
                                dir = 1'b0;
                            end
                            stin_next = dir;
                            if (dir)
                            begin
                                ht_next = ht_reg + 8'd1;
                                if (cmd_reg[4])
                                begin
                                    trk_next = trk_reg + 8'd1;
                                end
                            end
                            else
                            begin
                                ht_next = ht_dec;
                                if (cmd_reg[4])
                                begin
                                    trk_next = trk_reg - 8'd1;
                                end
                                if (ht_dec == 8'd0)
                                begin
                                    trk_next = 8'd0;
                                end
                            end
                        end
                    end
                    else if (cmd_reg[7:6] == 2'b10)
                    begin
                        // Type II: sector read or write.
                        drq_next    = 1'b0;
                        irq_next    = 1'b0;
                        status_next = ST_BUSY;
                        pos_next    = POS_W'(SECTOR_BYTES);
                        if (ssv_reg && cmd_reg[1])
                        begin
                            hs_next = cmd_reg[3];
                        end
                        if (!cmd_reg[5])
                        begin
                            lk_next    = LK_RDSEC;
                            state_next = S_LOC1;
                        end
                        else if (wp_reg)
                        begin
                            status_next = ST_WP;
                            irq_next    = 1'b1;
                        end
                        else
                        begin
                            lk_next    = LK_WRCMD;
                            state_next = S_LOC1;
                        end
                    end
                    else if (cmd_reg[7:4] != CMD_FORCE)
                    begin
                        // Type III: read address, read track, write track.
                        drq_next = 1'b0;
                        irq_next = 1'b1;
                        pos_next = POS_W'(SECTOR_BYTES);
                        if (!cmd_reg[5])
                        begin
                            if (img_reg && ht_reg < {1'b0, tc_reg} &&
                                {1'b0, hs_reg} < sc_reg)
                            begin
                                irq_next    = 1'b0;
                                status_next = ST_BUSY;
                                cnt_next    = '0;
                                state_next  = S_IDBYTES;
                            end
                            else
                            begin
                                status_next = ST_RNF;
                            end
                        end
                        else if (!cmd_reg[4])
                        begin
                            status_next = ST_NRDY;
                        end
                        else
                        begin
                            status_next = ST_SPIN;
                        end
                    end
                    else
                    begin
                        // Type IV: force interrupt, flushing a partial sector write.
                        drq_next = 1'b0;
                        st = (status_reg & ST_BUSY) | ST_SPIN;
                        if (wp_reg)
                        begin
                            st = st | ST_WP;
                        end
                        if (img_reg)
                        begin
                            st = st | ST_DRQ;
                            if (ht_reg == 8'd0)
                            begin
                                st = st | ST_TRK0;
                            end
                        end
                        status_next = st;
                        state_next  = S_T4FIN;
                        if (last_reg[7:5] == CMD_WRSECT && status_reg[0] &&
                            pos_reg != '0 && pos_reg < POS_W'(SECTOR_BYTES))
                        begin
                            state_next = S_FILL;
                        end
                    end
                end
            end

            S_SEEK:
            begin
                if (trk_reg != dat_reg && cnt_reg != STEP_LIMIT)
                begin
                    cnt_next = cnt_reg + 11'd1;
                    if (stin_reg)
                    begin
                        ht_next  = ht_reg + 8'd1;
                        trk_next = trk_reg + 8'd1;
                    end
                    else
                    begin
                        ht_next  = ht_dec;
                        trk_next = (ht_dec == 8'd0) ? 8'd0 : trk_reg - 8'd1;
                    end
                end
                else
                begin
                    state_next = S_T1FIN;
                end
            end

            S_T1FIN:
            begin
                st = status_reg;
                if (wp_reg)
                begin
                    st = st | ST_WP;
                end
                if (cmd_reg[2] && (!img_reg || ht_reg >= {1'b0, tc_reg} ||
                                   ht_reg != trk_reg))
                begin
                    st = st | ST_RNF;
                end
                if (img_reg)
                begin
                    st = st | ST_DRQ;
                    if (ht_reg == 8'd0)
                    begin
                        st = st | ST_TRK0;
                    end
                end
                status_next = st & ~ST_BUSY;
                irq_next    = 1'b1;
                state_next  = S_DONE;
            end

            S_LOC1: state_next = S_LOC2;
            S_LOC2: state_next = S_LOC3;

            S_LOC3:
            begin
                state_next = S_DONE;
                if (loc_ok)
                begin
                    act_next = loc_act;
                end
                case (lk_reg)
                    LK_RDSEC:
                    begin
                        if (!loc_ok)
                        begin
                            status_next = ST_RNF;
                            irq_next    = 1'b1;
                        end
                        else if (!loc_in_store)
                        begin
                            status_next = ST_CRC;
                            irq_next    = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            state_next = S_RDSEC;
                        end
                    end
                    LK_WRCMD:
                    begin
                        if (loc_ok)
                        begin
                            drq_next    = 1'b1;
                            status_next = status_reg | ST_DRQ;
                            pos_next    = '0;
                        end
                        else
                        begin
                            status_next = ST_RNF;
                            irq_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (loc_ok && loc_in_store)
                        begin
                            cnt_next   = '0;
                            flush_next = 1'b0;
                            state_next = S_WRSEC;
                        end
                        else
                        begin
                            status_next = status_reg | (loc_ok ? ST_SPIN : ST_RNF);
                            last_next   = 8'd0;
                            irq_next    = 1'b1;
                        end
                    end
                endcase
            end

            S_RDSEC:
            begin
                if (cnt_reg != '0)
                begin
                    sb_we    = 1'b1;
                    sb_waddr = BUF_AW'(cnt_reg - 11'd1);
                    sb_wdata = im_q;
                end
                if (cnt_reg == 11'(SECTOR_BYTES))
                begin
                    drq_next    = 1'b1;
                    status_next = status_reg | ST_DRQ;
                    pos_next    = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 11'd1;
                end
            end

            S_WRSEC:
            begin
                sb_raddr = cnt_reg[BUF_AW-1:0];
                if (cnt_reg != '0)
                begin
                    im_we = 1'b1;
                end
                if (cnt_reg == 11'(SECTOR_BYTES))
                begin
                    if (flush_reg)
                    begin
                        state_next = S_T4FIN;
                    end
                    else if (last_reg[4])
                    begin
                        sec_next   = sec_reg + 8'd1;
                        cmd_next   = last_reg;
                        state_next = S_CMD;
                    end
                    else
                    begin
                        last_next  = 8'd0;
                        irq_next   = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 11'd1;
                end
            end

            S_FILL:
            begin
                sb_we    = 1'b1;
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == POS_W'(SECTOR_BYTES - 1))
                begin
                    state_next = S_T4FIN;
                    if (img_reg && !wp_reg && act_reg < ACT_W'(IMAGE_SECTORS))
                    begin
                        cnt_next   = '0;
                        flush_next = 1'b1;
                        state_next = S_WRSEC;
                    end
                end
            end

            S_IDBYTES:
            begin
                sb_we    = 1'b1;
                sb_waddr = BUF_AW'(ID_POS + POS_W'(cnt_reg[2:0]));
                case (cnt_reg[2:0])
                    3'd0:    sb_wdata = ht_reg;
                    3'd1:    sb_wdata = {7'd0, hs_reg};
                    3'd2:    sb_wdata = 8'h01;
                    3'd3:    sb_wdata = 8'h02;
                    default: sb_wdata = 8'hFF;
                endcase
                cnt_next = cnt_reg + 11'd1;
                if (cnt_reg[2:0] == 3'd5)
                begin
                    pos_next    = ID_POS;
                    drq_next    = 1'b1;
                    status_next = status_reg | ST_DRQ;
                    state_next  = S_DONE;
                end
            end

            S_T4FIN:
            begin
                status_next = status_reg & ~ST_BUSY;
                last_next   = cmd_reg;
                if (cmd_reg[3:2] != 2'b00)
                begin
                    irq_next = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                rd_next = 8'd0;
                if (op_reg == OP_READ)
                begin
                    case (sel_reg)
                        REG_STATUS:
                            rd_next = ssv_reg ? (status_reg & ~ST_NRDY)
                                              : (status_reg | ST_NRDY);
                        REG_TRACK:  rd_next = trk_reg;
                        REG_SECTOR: rd_next = sec_reg;
                        default:    rd_next = dat_reg;
                    endcase
                end
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // A data request always points into the sector buffer.
    a_drq_pos: assert property (@(posedge clk) disable iff (!rst_n)
        drq_reg |-> (pos_reg < POS_W'(SECTOR_BYTES)))
        else $error("data request with buffer position outside the sector");

    // No result is offered while an operation is still being worked on.
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !m_tvalid)
        else $error("result offered while sequencer busy");

    // Every accepted transfer starts the sequencer.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted transfer did not start the sequencer");

endmodule
